### hdl/prad_pkg.sv
`default_nettype none

package prad_pkg;

    // Field and register widths.
    localparam int DIM_BITS  = 14;
    localparam int FRAC_BITS = 24;
    localparam int FACT_W    = 11;
    localparam int AREA_W    = 28;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AREA     = 2'd2;

    // Aspect ratio limit (long side over short side).
    localparam int ASPECT_LIMIT = 200;
    localparam int ASPECT_W     = 8;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Derived widths.
    // RN_W: rounding dividend 2*side + factor.
    localparam int RN_W  = ((DIM_BITS + 1 > FACT_W) ? DIM_BITS + 1 : FACT_W) + 1;
    // HB_W: a rounded side, at most side + factor/2.
    localparam int HB_W  = ((DIM_BITS > FACT_W) ? DIM_BITS : FACT_W) + 1;
    localparam int TOT_W = 2 * HB_W;
    localparam int FD_W  = (RN_W > OUT_W) ? RN_W : OUT_W;
    localparam int DEN_W = 2 * DIM_BITS;
    // The area quotient num * 2^(2*FRAC_BITS) / den always has an even width.
    localparam int QW    = AREA_W + 2 * FRAC_BITS;
    localparam int S_W   = QW / 2;
    localparam int T_W   = DIM_BITS + S_W;
    localparam int U_W   = ((T_W - FRAC_BITS > FACT_W) ? T_W - FRAC_BITS : FACT_W) + 1;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_DOWN,
        MODE_UP
    } mode_t;

    typedef struct packed {
        logic [FACT_W-1:0] fact;
        logic [AREA_W-1:0] min_area;
        logic [AREA_W-1:0] max_area;
    } cfg_t;

    // Per-item data that travels the whole pipeline.
    typedef struct packed {
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic                bad;
        logic                asp;
        mode_t               mode;
        logic [RN_W-1:0]     qh;
        logic [RN_W-1:0]     qw;
        logic [OUT_W-1:0]    lim;
    } info_t;

    typedef struct packed {
        info_t             info;
        logic [AREA_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } fs_t;

    typedef struct packed {
        info_t          info;
        logic [S_W-1:0] scale;
    } sb_t;

    typedef struct packed {
        logic [OUT_W-1:0] height;
        logic [OUT_W-1:0] width;
        logic             bad;
        logic             warn;
    } res_t;

endpackage

`default_nettype wire

### hdl/prad_front.sv
`default_nettype none

module prad_front import prad_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [DIM_BITS-1:0] in_height,
    input  logic [DIM_BITS-1:0] in_width,
    input  cfg_t                cfg,
    output logic                out_valid,
    output fs_t                 out_item
);

    localparam int NS = FD_W + 4;
    localparam int RW = FACT_W + 1;
    localparam int CW = (TOT_W > AREA_W) ? TOT_W : AREA_W;
    localparam int AW = DIM_BITS + ASPECT_W;
    localparam int PW = RN_W + FACT_W;

    typedef struct packed {
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic                bad;
        logic                asp;
        logic [RW-1:0]       rh;
        logic [RW-1:0]       rw;
        logic [RW-1:0]       rl;
        logic [FD_W-1:0]     dh;
        logic [FD_W-1:0]     dw;
        logic [FD_W-1:0]     dl;
        logic [HB_W-1:0]     hb;
        logic [HB_W-1:0]     wb;
        logic [DEN_W-1:0]    den;
        logic [TOT_W-1:0]    total;
        mode_t               mode;
        logic [AREA_W-1:0]   num;
    } fr_t;

    fr_t             st_reg  [NS];
    fr_t             st_next [NS];
    logic [NS-1:0]   vld_reg;

    // One restoring division step; the quotient shifts in where the dividend shifts out.
    function automatic logic [RW+FD_W-1:0] div_step(input logic [RW-1:0]   rem,
                                                    input logic [FD_W-1:0] dq,
                                                    input logic [RW-1:0]   d);
        logic [RW:0] t;
        logic        ge;
        t  = {rem, dq[FD_W-1]};
        ge = (t >= {1'b0, d});
        div_step = {(ge ? RW'(t - {1'b0, d}) : t[RW-1:0]), dq[FD_W-2:0], ge};
    endfunction

    always_comb begin
        fr_t                     cur;
        logic [RW-1:0]           d2;
        logic [RW-1:0]           d1;
        logic [DIM_BITS-1:0]     lo;
        logic [DIM_BITS-1:0]     hi;
        logic [AW-1:0]           lo200;
        logic [PW-1:0]           ph;
        logic [PW-1:0]           pw;

        d2 = {cfg.fact, 1'b0};
        d1 = {1'b0, cfg.fact};

        st_next[0]   = '0;
        st_next[0].h = in_height;
        st_next[0].w = in_width;

        for (int i = 1; i < NS; i++) begin
            cur   = st_reg[i-1];
            lo    = '0;
            hi    = '0;
            lo200 = '0;
            ph    = '0;
            pw    = '0;
            if (i == 1) begin
                lo       = (cur.h < cur.w) ? cur.h : cur.w;
                hi       = (cur.h < cur.w) ? cur.w : cur.h;
                lo200    = AW'(lo) * AW'(ASPECT_LIMIT);
                cur.bad  = (cur.h == '0) || (cur.w == '0);
                cur.asp  = (AW'(hi) > lo200);
                cur.dh   = (FD_W'(cur.h) << 1) + FD_W'(cfg.fact);
                cur.dw   = (FD_W'(cur.w) << 1) + FD_W'(cfg.fact);
                cur.dl   = FD_W'(OUT_MAX);
                cur.rh   = '0;
                cur.rw   = '0;
                cur.rl   = '0;
            end
            if (i <= FD_W) begin
                {cur.rh, cur.dh} = div_step(cur.rh, cur.dh, d2);
                {cur.rw, cur.dw} = div_step(cur.rw, cur.dw, d2);
                {cur.rl, cur.dl} = div_step(cur.rl, cur.dl, d1);
            end else if (i == FD_W + 1) begin
                ph      = PW'(cur.dh[RN_W-1:0]) * PW'(cfg.fact);
                pw      = PW'(cur.dw[RN_W-1:0]) * PW'(cfg.fact);
                cur.hb  = ph[HB_W-1:0];
                cur.wb  = pw[HB_W-1:0];
                cur.den = DEN_W'(cur.h) * DEN_W'(cur.w);
            end else if (i == FD_W + 2) begin
                cur.total = TOT_W'(cur.hb) * TOT_W'(cur.wb);
            end else begin
                // The upper bound is tested first, as a bad pair of limits requires.
                if (CW'(cur.total) > CW'(cfg.max_area)) begin
                    cur.mode = MODE_DOWN;
                    cur.num  = cfg.max_area;
                end else if (CW'(cur.total) < CW'(cfg.min_area)) begin
                    cur.mode = MODE_UP;
                    cur.num  = cfg.min_area;
                end else begin
                    cur.mode = MODE_KEEP;
                    cur.num  = '0;
                end
            end
            st_next[i] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid          = vld_reg[NS-1];
    assign out_item.info.h    = st_reg[NS-1].h;
    assign out_item.info.w    = st_reg[NS-1].w;
    assign out_item.info.bad  = st_reg[NS-1].bad;
    assign out_item.info.asp  = st_reg[NS-1].asp;
    assign out_item.info.mode = st_reg[NS-1].mode;
    assign out_item.info.qh   = st_reg[NS-1].dh[RN_W-1:0];
    assign out_item.info.qw   = st_reg[NS-1].dw[RN_W-1:0];
    assign out_item.info.lim  = st_reg[NS-1].dl[OUT_W-1:0];
    assign out_item.num       = st_reg[NS-1].num;
    assign out_item.den       = st_reg[NS-1].den;

endmodule

`default_nettype wire

### hdl/prad_scale.sv
`default_nettype none

module prad_scale import prad_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  fs_t  in_item,
    output logic out_valid,
    output sb_t  out_item
);

    // QW division steps for the area quotient, then S_W square root steps.
    localparam int NS   = QW + S_W;
    localparam int SR_W = S_W + 1;

    typedef struct packed {
        info_t            info;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rd;
        logic [QW-1:0]    dq;
        logic [SR_W-1:0]  rs;
        logic [S_W-1:0]   root;
    } sc_t;

    sc_t           st_reg  [NS];
    sc_t           st_next [NS];
    logic [NS-1:0] vld_reg;

    always_comb begin
        sc_t              cur;
        logic [DEN_W:0]   td;
        logic [SR_W+1:0]  ts;
        logic [SR_W+1:0]  trial;
        logic             ge;

        for (int i = 0; i < NS; i++) begin
            td    = '0;
            ts    = '0;
            trial = '0;
            ge    = 1'b0;
            if (i == 0) begin
                cur      = '0;
                cur.info = in_item.info;
                cur.den  = in_item.den;
                cur.dq   = {in_item.num, {(2 * FRAC_BITS){1'b0}}};
            end else begin
                cur = st_reg[i-1];
            end
            if (i < QW) begin
                td     = {cur.rd, cur.dq[QW-1]};
                ge     = (td >= {1'b0, cur.den});
                cur.rd = ge ? DEN_W'(td - {1'b0, cur.den}) : td[DEN_W-1:0];
                cur.dq = {cur.dq[QW-2:0], ge};
            end else begin
                // Digit-by-digit square root, two radicand bits per step.
                ts       = {cur.rs, cur.dq[QW-1 -: 2]};
                trial    = {1'b0, cur.root, 2'b01};
                ge       = (ts >= trial);
                cur.rs   = ge ? SR_W'(ts - trial) : ts[SR_W-1:0];
                cur.root = {cur.root[S_W-2:0], ge};
                cur.dq   = {cur.dq[QW-3:0], 2'b00};
            end
            st_next[i] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid      = vld_reg[NS-1];
    assign out_item.info  = st_reg[NS-1].info;
    assign out_item.scale = st_reg[NS-1].root;

endmodule

`default_nettype wire

### hdl/prad_back.sv
`default_nettype none

module prad_back import prad_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [FACT_W-1:0] fact,
    input  logic              in_valid,
    input  sb_t               in_item,
    output logic              out_valid,
    output res_t              out_item
);

    localparam int NS  = U_W + 4;
    localparam int KW0 = (U_W > RN_W) ? U_W : RN_W;
    localparam int KW  = (KW0 > OUT_W) ? KW0 : OUT_W;
    localparam int PW  = OUT_W + FACT_W;

    typedef struct packed {
        info_t             info;
        logic [T_W-1:0]    th;
        logic [T_W-1:0]    tw;
        logic [FACT_W-1:0] rh;
        logic [FACT_W-1:0] rw;
        logic [U_W-1:0]    dh;
        logic [U_W-1:0]    dw;
        logic [OUT_W-1:0]  mh;
        logic [OUT_W-1:0]  mw;
        res_t              res;
    } bk_t;

    bk_t           st_reg  [NS];
    bk_t           st_next [NS];
    logic [NS-1:0] vld_reg;

    function automatic logic [FACT_W+U_W-1:0] div_step(input logic [FACT_W-1:0] rem,
                                                       input logic [U_W-1:0]    dq,
                                                       input logic [FACT_W-1:0] d);
        logic [FACT_W:0] t;
        logic            ge;
        t  = {rem, dq[U_W-1]};
        ge = (t >= {1'b0, d});
        div_step = {(ge ? FACT_W'(t - {1'b0, d}) : t[FACT_W-1:0]), dq[U_W-2:0], ge};
    endfunction

    function automatic logic [OUT_W-1:0] clamp_units(input mode_t            mode,
                                                     input logic [U_W-1:0]   k,
                                                     input logic [RN_W-1:0]  q,
                                                     input logic [OUT_W-1:0] lim);
        logic [KW-1:0] u;
        case (mode)
            MODE_DOWN: u = (k == '0) ? KW'(1) : KW'(k);
            MODE_UP:   u = KW'(k);
            MODE_KEEP: u = KW'(q);
            default:   u = KW'(q);
        endcase
        clamp_units = (u > KW'(lim)) ? lim : u[OUT_W-1:0];
    endfunction

    always_comb begin
        bk_t                      cur;
        logic                     up;
        logic [U_W-1:0]           adj;
        logic [PW-1:0]            ph;
        logic [PW-1:0]            pw;

        for (int i = 0; i < NS; i++) begin
            up  = 1'b0;
            adj = '0;
            ph  = '0;
            pw  = '0;
            if (i == 0) begin
                cur      = '0;
                cur.info = in_item.info;
                cur.th   = T_W'(in_item.info.h) * T_W'(in_item.scale);
                cur.tw   = T_W'(in_item.info.w) * T_W'(in_item.scale);
            end else begin
                cur = st_reg[i-1];
            end
            if (i == 1) begin
                // Rounding up is a ceiling of the fraction followed by a ceiling over the factor.
                up     = (cur.info.mode == MODE_UP);
                adj    = up ? (U_W'(fact) - U_W'(1)) : '0;
                cur.dh = U_W'(cur.th[T_W-1:FRAC_BITS])
                       + U_W'(up && (cur.th[FRAC_BITS-1:0] != '0)) + adj;
                cur.dw = U_W'(cur.tw[T_W-1:FRAC_BITS])
                       + U_W'(up && (cur.tw[FRAC_BITS-1:0] != '0)) + adj;
                cur.rh = '0;
                cur.rw = '0;
            end else if (i >= 2 && i <= U_W + 1) begin
                {cur.rh, cur.dh} = div_step(cur.rh, cur.dh, fact);
                {cur.rw, cur.dw} = div_step(cur.rw, cur.dw, fact);
            end else if (i == U_W + 2) begin
                cur.mh = cur.info.bad ? '0
                       : clamp_units(cur.info.mode, cur.dh, cur.info.qh, cur.info.lim);
                cur.mw = cur.info.bad ? '0
                       : clamp_units(cur.info.mode, cur.dw, cur.info.qw, cur.info.lim);
            end else if (i == U_W + 3) begin
                ph             = PW'(cur.mh) * PW'(fact);
                pw             = PW'(cur.mw) * PW'(fact);
                cur.res.height = ph[OUT_W-1:0];
                cur.res.width  = pw[OUT_W-1:0];
                cur.res.bad    = cur.info.bad;
                cur.res.warn   = cur.info.asp && !cur.info.bad;
            end
            st_next[i] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_item  = st_reg[NS-1].res;

endmodule

`default_nettype wire

### hdl/patch_aligned_resize_dims_core.sv
`default_nettype none
// The pipeline depth comes from bit-serial pipelines: the rounding divider, the 76-step area divider,
// the 38-step square root and the 29-step divider by the factor, one bit per stage.
// Throughput: one transaction per cycle; a held result stalls the whole pipeline only
// when its last stage is occupied.
// Reset (aresetn low at a clock edge) empties the pipeline and restores the register defaults.
module patch_aligned_resize_dims_core import prad_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DIM_BITS-1:0]  s_in_height,
    input  logic [DIM_BITS-1:0]  s_in_width,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_out_height,
    output logic [OUT_W-1:0]     m_out_width,
    output logic                 m_bad_size,
    output logic                 m_aspect_warn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AREA_W-1:0]    cfg_data
);

    localparam logic [FACT_W-1:0] FACT_RESET = 11'd32;
    localparam logic [AREA_W-1:0] MIN_RESET  = 28'd65536;
    localparam logic [AREA_W-1:0] MAX_RESET  = 28'd16777216;

    logic [FACT_W-1:0] align_factor_reg;
    logic [AREA_W-1:0] min_area_reg;
    logic [AREA_W-1:0] max_area_reg;
    cfg_t              cfg;

    logic adv;
    logic out_load;
    logic m_valid_reg;
    res_t res_reg;

    logic front_valid;
    fs_t  front_item;
    logic scale_valid;
    sb_t  scale_item;
    logic back_valid;
    res_t back_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_factor_reg <= FACT_RESET;
            min_area_reg     <= MIN_RESET;
            max_area_reg     <= MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ALIGN_FACTOR: align_factor_reg <= cfg_data[FACT_W-1:0];
                REG_MIN_AREA:     min_area_reg     <= cfg_data;
                REG_MAX_AREA:     max_area_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A factor of zero behaves as one.
    assign cfg.fact     = (align_factor_reg == '0) ? FACT_W'(1) : align_factor_reg;
    assign cfg.min_area = min_area_reg;
    assign cfg.max_area = max_area_reg;

    // The pipeline moves whenever its last stage can drain or holds a bubble.
    assign out_load = m_ready || !m_valid_reg;
    assign adv      = out_load || !back_valid;
    assign s_ready  = adv;

    prad_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_height (s_in_height),
        .in_width  (s_in_width),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    prad_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (scale_valid),
        .out_item  (scale_item)
    );

    prad_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .fact      (cfg.fact),
        .in_valid  (scale_valid),
        .in_item   (scale_item),
        .out_valid (back_valid),
        .out_item  (back_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= back_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg <= back_item;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_height  = res_reg.height;
    assign m_out_width   = res_reg.width;
    assign m_bad_size    = res_reg.bad;
    assign m_aspect_warn = res_reg.warn;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_size) |->
            (m_out_height == '0) && (m_out_width == '0) && !m_aspect_warn)
        else $error("bad size result carries nonzero sides or a warning");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && back_valid))
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

### tb/patch_aligned_resize_dims_core_tb.sv
`timescale 1ns / 1ps

module patch_aligned_resize_dims_core_tb;
    import prad_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // An index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        row_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [AREA_W-1:0]   data;
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic                typed;
        res_t                res;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [DIM_BITS-1:0]  s_in_height = '0;
    logic [DIM_BITS-1:0]  s_in_width = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_W-1:0]     m_out_height;
    logic [OUT_W-1:0]     m_out_width;
    logic                 m_bad_size;
    logic                 m_aspect_warn;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [AREA_W-1:0]    cfg_data = '0;

    // Shadow copy of the block's registers.
    logic [FACT_W-1:0] fact_r = 11'd32;
    logic [AREA_W-1:0] min_r = 28'd65536;
    logic [AREA_W-1:0] max_r = 28'd16777216;

    res_t expected_dims[$];
    int   mismatches = 0;

    patch_aligned_resize_dims_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_height(s_in_height), .s_in_width(s_in_width),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_height(m_out_height), .m_out_width(m_out_width),
        .m_bad_size(m_bad_size), .m_aspect_warn(m_aspect_warn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // Largest fixed-point scale s with s*s*den <= num * 2^(2*FRAC_BITS).
    function automatic logic [63:0] area_root(logic [63:0] num, logic [63:0] den);
        logic [127:0] cand;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  s;
        s = '0;
        rhs = {64'd0, num} << (2 * FRAC_BITS);
        for (int b = FRAC_BITS + 14; b >= 0; b--) begin
            cand = {64'd0, s | (64'd1 << b)};
            lhs = cand * cand * {64'd0, den};
            if (lhs <= rhs) begin
                s = cand[63:0];
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] snap_side(logic [63:0] side, logic [63:0] s,
                                              logic [63:0] f, logic up);
        logic [63:0] prod;
        logic [63:0] unit;
        prod = side * s;
        unit = f << FRAC_BITS;
        return (up ? (prod + unit - 1) / unit : prod / unit) * f;
    endfunction

    function automatic res_t predict_dims(logic [DIM_BITS-1:0] hin, logic [DIM_BITS-1:0] win);
        logic [63:0] h, w, f, hb, wb, total, s, lo, hi, lim;
        res_t r;
        h = 64'(hin);
        w = 64'(win);
        f = (fact_r == 0) ? 64'd1 : 64'(fact_r);
        if (h == 0 || w == 0) begin
            r.height = '0;
            r.width = '0;
            r.bad = 1'b1;
            r.warn = 1'b0;
            return r;
        end
        lo = (h < w) ? h : w;
        hi = (h < w) ? w : h;
        hb = ((2 * h + f) / (2 * f)) * f;
        wb = ((2 * w + f) / (2 * f)) * f;
        total = hb * wb;
        if (total > 64'(max_r)) begin
            s = area_root(64'(max_r), h * w);
            hb = snap_side(h, s, f, 1'b0);
            wb = snap_side(w, s, f, 1'b0);
            if (hb < f) hb = f;
            if (wb < f) wb = f;
        end else if (total < 64'(min_r)) begin
            s = area_root(64'(min_r), h * w);
            hb = snap_side(h, s, f, 1'b1);
            wb = snap_side(w, s, f, 1'b1);
        end
        lim = (64'(OUT_MAX) / f) * f;
        r.height = (hb > lim) ? lim[15:0] : hb[15:0];
        r.width = (wb > lim) ? lim[15:0] : wb[15:0];
        r.bad = 1'b0;
        r.warn = (hi > ASPECT_LIMIT * lo);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sends one transaction; the expectation is either given or predicted at acceptance.
    task automatic send_dims(logic [DIM_BITS-1:0] h, logic [DIM_BITS-1:0] w,
                             logic typed, res_t res);
        int gap;
        gap = $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_height <= h;
        s_in_width <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_dims.push_back(typed ? res : predict_dims(h, w));
    endtask

    // Registers change only once every pending result has drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AREA_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_dims.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ALIGN_FACTOR: fact_r = data[FACT_W-1:0];
            REG_MIN_AREA:     min_r = data;
            REG_MAX_AREA:     max_r = data;
            default: ;
        endcase
    endtask

    function automatic logic [DIM_BITS-1:0] rand_side();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5, 6: return DIM_BITS'($urandom());
            7, 8, 9, 10:   return DIM_BITS'($urandom_range(1, 255));
            default: return DIM_BITS'($urandom_range(1, 4095));
        endcase
    endfunction

    // Result side: random stalls, sometimes none for a while.
    always begin
        int   stall;
        res_t exp_r;
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (m_valid !== 1'b1);
        if (expected_dims.size() == 0) begin
            report_mismatch("result transaction with no expectation pending");
        end else begin
            exp_r = expected_dims.pop_front();
            if (m_out_height !== exp_r.height)
                report_mismatch($sformatf("out_height %0d, expected %0d",
                                          m_out_height, exp_r.height));
            if (m_out_width !== exp_r.width)
                report_mismatch($sformatf("out_width %0d, expected %0d",
                                          m_out_width, exp_r.width));
            if (m_bad_size !== exp_r.bad)
                report_mismatch($sformatf("bad_size %b, expected %b", m_bad_size, exp_r.bad));
            if (m_aspect_warn !== exp_r.warn)
                report_mismatch($sformatf("aspect_warn %b, expected %b",
                                          m_aspect_warn, exp_r.warn));
        end
    end

    initial begin
        dir_row_t dir_tab[];
        res_t none;
        int   waited;
        logic [DIM_BITS-1:0] lo_side;

        dir_tab = '{
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd0, 14'd0, 1'b1, '{16'd0, 16'd0, 1'b1, 1'b0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd0, 14'd16383, 1'b1,
              '{16'd0, 16'd0, 1'b1, 1'b0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd16383, 14'd0, 1'b1,
              '{16'd0, 16'd0, 1'b1, 1'b0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd1024, 14'd1024, 1'b1,
              '{16'd1024, 16'd1024, 1'b0, 1'b0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd16383, 14'd16383, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd1, 14'd1, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd1, 14'd16383, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd200, 14'd1, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd201, 14'd1, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd224, 14'd224, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_ALIGN_FACTOR, 28'd0, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd0, 14'd3, 1'b1, '{16'd0, 16'd0, 1'b1, 1'b0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd333, 14'd777, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_ALIGN_FACTOR, 28'd2047, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd16383, 14'd16383, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd1, 14'd1, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_ALIGN_FACTOR, 28'd32, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_MAX_AREA, 28'd0, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd100, 14'd100, 1'b1,
              '{16'd32, 16'd32, 1'b0, 1'b0}},
            '{ROW_CFG, REG_MAX_AREA, 28'hFFFFFFF, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_MIN_AREA, 28'hFFFFFFF, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd16383, 14'd16383, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd1, 14'd16383, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_MIN_AREA, 28'd0, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_CFG, REG_SPARE, 28'h5A5A5A5, 14'd0, 14'd0, 1'b0, '{0, 0, 0, 0}},
            '{ROW_ITEM, REG_ALIGN_FACTOR, 28'd0, 14'd5, 14'd9, 1'b0, '{0, 0, 0, 0}}
        };
        none = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            else
                send_dims(dir_tab[i].h, dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
        end

        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 7))
                0:       write_reg(REG_ALIGN_FACTOR, 28'd0);
                1:       write_reg(REG_ALIGN_FACTOR, 28'd1);
                2:       write_reg(REG_ALIGN_FACTOR, 28'd2047);
                3:       write_reg(REG_ALIGN_FACTOR, 28'd1024);
                4:       write_reg(REG_ALIGN_FACTOR, AREA_W'($urandom_range(0, 2047)));
                default: write_reg(REG_ALIGN_FACTOR, AREA_W'($urandom_range(1, 64)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_MIN_AREA, 28'd0);
                1:       write_reg(REG_MIN_AREA, 28'hFFFFFFF);
                2:       write_reg(REG_MIN_AREA, AREA_W'($urandom()));
                default: write_reg(REG_MIN_AREA, AREA_W'($urandom_range(1, 1 << 22)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_MAX_AREA, 28'd0);
                1:       write_reg(REG_MAX_AREA, 28'hFFFFFFF);
                2:       write_reg(REG_MAX_AREA, AREA_W'($urandom()));
                default: write_reg(REG_MAX_AREA, AREA_W'($urandom_range(1 << 20, 1 << 26)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, AREA_W'($urandom()));
            for (int n = 0; n < 150; n++) begin
                // A share of items sits near the aspect ratio threshold.
                if ($urandom_range(0, 9) == 0) begin
                    lo_side = DIM_BITS'($urandom_range(1, 81));
                    if ($urandom_range(0, 1))
                        send_dims(lo_side,
                                  DIM_BITS'(lo_side * 200 + $urandom_range(0, 2) - 1),
                                  1'b0, none);
                    else
                        send_dims(DIM_BITS'(lo_side * 200 + $urandom_range(0, 2) - 1),
                                  lo_side, 1'b0, none);
                end else begin
                    send_dims(rand_side(), rand_side(), 1'b0, none);
                end
            end
        end

        s_valid <= 1'b0;
        waited = 0;
        while (expected_dims.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && expected_dims.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### patch_aligned_resize_dims_core.f
hdl/prad_pkg.sv
hdl/prad_front.sv
hdl/prad_scale.sv
hdl/prad_back.sv
hdl/patch_aligned_resize_dims_core.sv
tb/patch_aligned_resize_dims_core_tb.sv
